### hdl/credit_output_port_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the credit output port allocator
// Shared overlapped-implication and next-cycle check forms.
// ----------------------------------------------------------------------------
`ifndef CREDIT_OUTPUT_PORT_ALLOCATOR_TOP_MACROS_SVH
`define CREDIT_OUTPUT_PORT_ALLOCATOR_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define COPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define COPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/copa_pkg.sv
// ----------------------------------------------------------------------------
// copa_pkg
// Sizes, register codes and helpers for the credit output port allocator.
// ----------------------------------------------------------------------------
package copa_pkg;

   localparam int NUM_VCS     = 4;
   localparam int NUM_SOURCES = 4;

   localparam int VC_W  = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
   localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   localparam int MASK_W      = 16;
   localparam int MASK_IDX_W  = $clog2(MASK_W);
   localparam int CREDIT_W    = 8;
   localparam int FLITS_W     = 8;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_IDX_W   = 1;
   localparam int FIELD_VC_W  = 2;
   localparam int FIELD_SRC_W = 2;

   localparam logic [FLITS_W-1:0]  RESET_PACKET_FLITS    = 8'd4;
   localparam logic [CREDIT_W-1:0] RESET_CREDIT_CAPACITY = 8'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PACKET_FLITS    = 1'b0,
      CSR_CREDIT_CAPACITY = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      FUNC_TICK          = 1'b0,
      FUNC_CREDIT_RETURN = 1'b1
   } func_type;

   typedef logic [NUM_SOURCES-1:0] src_vec_type;

   // Gather the bits of one virtual channel, one per source port.
   function automatic src_vec_type vc_column(logic [MASK_W-1:0] mask, int unsigned vc);
      src_vec_type col;
      int unsigned idx;
      col = '0;
      for (int unsigned p = 0; p < NUM_SOURCES; p++) begin
         idx = p * NUM_VCS + vc;
         if (idx < MASK_W) begin
            col[p] = mask[idx[MASK_IDX_W-1:0]];
         end
      end
      return col;
   endfunction

   // base + step modulo NUM_SOURCES, step at most NUM_SOURCES.
   function automatic logic [SRC_W-1:0] wrap_src(logic [SRC_W-1:0] base, int unsigned step);
      logic [SRC_W:0] sum;
      sum = (SRC_W+1)'(base) + (SRC_W+1)'(step);
      if (sum >= (SRC_W+1)'(NUM_SOURCES)) begin
         sum = sum - (SRC_W+1)'(NUM_SOURCES);
      end
      return sum[SRC_W-1:0];
   endfunction

   // base + step modulo NUM_VCS, step at most NUM_VCS.
   function automatic logic [VC_W-1:0] wrap_vc(logic [VC_W-1:0] base, int unsigned step);
      logic [VC_W:0] sum;
      sum = (VC_W+1)'(base) + (VC_W+1)'(step);
      if (sum >= (VC_W+1)'(NUM_VCS)) begin
         sum = sum - (VC_W+1)'(NUM_VCS);
      end
      return sum[VC_W-1:0];
   endfunction

endpackage

### hdl/credit_output_port_allocator_top.sv
// ----------------------------------------------------------------------------
// credit_output_port_allocator_top
// Virtual channel and round-robin flit allocation for one router output port.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one word per tick or credit return:
//   req_func selects a clock-tick allocation step or a credit return,
//   the two masks give buffer occupancy and front-tail bits per source port
//   and virtual channel, req_credit_vc names the channel of a returned credit.
//   rsp channel (valid/ready) returns exactly one word per request word:
//   whether a flit was sent, its channel, its source port and its tail bit.
//   csr port writes packet_flits (index 0) and credit_capacity (index 1);
//   write it only while the block is idle.
//   An accepted word is registered in the input stage, evaluated there
//   and registered in the result register that drives rsp. Throughput:
//   one word per cycle while rsp does not stall; the allocation state
//   (credits, owners, round-robin pointers) updates in the same cycle
//   that the word leaves the input stage.
//   Reset (synchronous) empties both stages, restores the register defaults,
//   fills every channel's credit to 16 and frees every channel.
//   When rsp stalls, the result register holds and the input stage holds one
//   more word; req_ready drops only when both are full.
// ----------------------------------------------------------------------------
`include "credit_output_port_allocator_top_macros.svh"

module credit_output_port_allocator_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [copa_pkg::MASK_W-1:0]        req_occupied_mask,
   input  logic [copa_pkg::MASK_W-1:0]        req_front_tail_mask,
   input  logic [copa_pkg::FIELD_VC_W-1:0]    req_credit_vc,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_sent,
   output logic [copa_pkg::FIELD_VC_W-1:0]    rsp_sent_vc,
   output logic [copa_pkg::FIELD_SRC_W-1:0]   rsp_sent_source,
   output logic                               rsp_sent_tail,
   // configuration write port
   input  logic                               csr_write_enable,
   input  logic [copa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [copa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import copa_pkg::*;

   // configuration registers
   logic [FLITS_W-1:0]     packet_flits_ff;
   logic [CREDIT_W-1:0]    credit_capacity_ff;

   // input stage
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_func_ff;
   logic [MASK_W-1:0]      s1_occ_ff;
   logic [MASK_W-1:0]      s1_tail_ff;
   logic [FIELD_VC_W-1:0]  s1_cvc_ff;

   // allocation state
   logic [CREDIT_W-1:0]    vc_credit_ff      [NUM_VCS];
   logic [CREDIT_W-1:0]    vc_credit_in      [NUM_VCS];
   logic [NUM_VCS-1:0]     owner_valid_ff, owner_valid_in;
   logic [SRC_W-1:0]       vc_owner_ff       [NUM_VCS];
   logic [SRC_W-1:0]       vc_owner_in       [NUM_VCS];
   logic [SRC_W-1:0]       vc_owner_last_ff  [NUM_VCS];
   logic [SRC_W-1:0]       vc_owner_last_in  [NUM_VCS];
   logic                   chosen_valid_ff, chosen_valid_in;
   logic [VC_W-1:0]        chosen_vc_ff, chosen_vc_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_sent_ff, rsp_sent_in;
   logic [FIELD_VC_W-1:0]  rsp_sent_vc_ff, rsp_sent_vc_in;
   logic [FIELD_SRC_W-1:0] rsp_sent_source_ff, rsp_sent_source_in;
   logic                   rsp_sent_tail_ff, rsp_sent_tail_in;

   // handshake
   logic                   advance;
   logic                   s1_fire;
   logic                   is_tick;

   // allocation datapath
   src_vec_type            occ_col   [NUM_VCS];
   src_vec_type            tail_col  [NUM_VCS];
   logic [NUM_VCS-1:0]     grant;
   logic [SRC_W-1:0]       grant_src [NUM_VCS];
   logic [NUM_VCS-1:0]     own1;
   logic [SRC_W-1:0]       owner1    [NUM_VCS];
   logic [NUM_VCS-1:0]     eligible;
   logic [VC_W-1:0]        scan_start;
   logic [VC_W-1:0]        cand_vc;
   logic [SRC_W-1:0]       cand_src;
   logic                   found;
   logic [VC_W-1:0]        sel_vc;
   logic [SRC_W-1:0]       sel_src;
   logic                   send;
   logic                   sel_tail;
   logic [VC_W-1:0]        ret_vc;

   // -------------------------------------------------------------------------
   // Handshake: the input stage advances whenever the result register is
   // empty or being drained this cycle.
   // -------------------------------------------------------------------------
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign is_tick   = (func_type'(s1_func_ff) == FUNC_TICK);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // -------------------------------------------------------------------------
   // Step 1: each free channel picks, round-robin after its last winner, the
   // first source port whose buffer holds a flit, when its credit covers a
   // whole packet. Scan from the far end so the nearest hit wins.
   // -------------------------------------------------------------------------
   always_comb begin
      cand_src = '0;
      for (int v = 0; v < NUM_VCS; v++) begin
         occ_col[v]   = vc_column(s1_occ_ff, v);
         tail_col[v]  = vc_column(s1_tail_ff, v);
         grant[v]     = 1'b0;
         grant_src[v] = vc_owner_last_ff[v];
         if (!owner_valid_ff[v] && (vc_credit_ff[v] >= packet_flits_ff)) begin
            for (int c = NUM_SOURCES; c >= 1; c--) begin
               cand_src = wrap_src(vc_owner_last_ff[v], c);
               if (occ_col[v][cand_src]) begin
                  grant[v]     = 1'b1;
                  grant_src[v] = cand_src;
               end
            end
         end
         own1[v]     = owner_valid_ff[v] || grant[v];
         owner1[v]   = grant[v] ? grant_src[v] : vc_owner_ff[v];
         eligible[v] = own1[v] && (vc_credit_ff[v] != '0);
      end
   end

   // -------------------------------------------------------------------------
   // Step 2: round-robin over owned channels with credit, starting after the
   // last chosen one. Step 3: forward from the chosen owner's buffer.
   // -------------------------------------------------------------------------
   always_comb begin
      scan_start = chosen_valid_ff ? wrap_vc(chosen_vc_ff, 1) : '0;
      found      = |eligible;
      sel_vc     = chosen_vc_ff;
      for (int c = NUM_VCS - 1; c >= 0; c--) begin
         cand_vc = wrap_vc(scan_start, c);
         if (eligible[cand_vc]) begin
            sel_vc = cand_vc;
         end
      end
      sel_src  = owner1[sel_vc];
      send     = found && occ_col[sel_vc][sel_src];
      sel_tail = tail_col[sel_vc][sel_src];
   end

   // -------------------------------------------------------------------------
   // State update: commit the tick or the credit return as the word leaves
   // the input stage.
   // -------------------------------------------------------------------------
   assign ret_vc = VC_W'(s1_cvc_ff);

   always_comb begin
      vc_credit_in     = vc_credit_ff;
      owner_valid_in   = owner_valid_ff;
      vc_owner_in      = vc_owner_ff;
      vc_owner_last_in = vc_owner_last_ff;
      chosen_valid_in  = chosen_valid_ff;
      chosen_vc_in     = chosen_vc_ff;
      if (s1_fire) begin
         case (func_type'(s1_func_ff))
            FUNC_CREDIT_RETURN: begin
               // saturate at capacity, drop returns to a missing channel
               if ((int'(s1_cvc_ff) < NUM_VCS) &&
                   (vc_credit_ff[ret_vc] < credit_capacity_ff)) begin
                  vc_credit_in[ret_vc] = vc_credit_ff[ret_vc] + 1'b1;
               end
            end
            FUNC_TICK: begin
               owner_valid_in = own1;
               vc_owner_in    = owner1;
               for (int v = 0; v < NUM_VCS; v++) begin
                  if (grant[v]) begin
                     vc_owner_last_in[v] = grant_src[v];
                  end
               end
               chosen_valid_in = found;
               if (found) begin
                  chosen_vc_in = sel_vc;
               end
               if (send) begin
                  vc_credit_in[sel_vc] = vc_credit_ff[sel_vc] - 1'b1;
                  if (sel_tail) begin
                     owner_valid_in[sel_vc] = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result word: all fields zero unless a flit goes out
   always_comb begin
      rsp_sent_in        = 1'b0;
      rsp_sent_vc_in     = '0;
      rsp_sent_source_in = '0;
      rsp_sent_tail_in   = 1'b0;
      if (is_tick && send) begin
         rsp_sent_in        = 1'b1;
         rsp_sent_vc_in     = FIELD_VC_W'(sel_vc);
         rsp_sent_source_in = FIELD_SRC_W'(sel_src);
         rsp_sent_tail_in   = sel_tail;
      end
   end

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         packet_flits_ff    <= RESET_PACKET_FLITS;
         credit_capacity_ff <= RESET_CREDIT_CAPACITY;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PACKET_FLITS:    packet_flits_ff    <= FLITS_W'(csr_wdata);
            CSR_CREDIT_CAPACITY: credit_capacity_ff <= CREDIT_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         owner_valid_ff  <= '0;
         chosen_valid_ff <= 1'b0;
         chosen_vc_ff    <= '0;
         for (int v = 0; v < NUM_VCS; v++) begin
            vc_credit_ff[v]     <= RESET_CREDIT_CAPACITY;
            vc_owner_last_ff[v] <= SRC_W'(NUM_SOURCES - 1);
         end
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         owner_valid_ff   <= owner_valid_in;
         chosen_valid_ff  <= chosen_valid_in;
         chosen_vc_ff     <= chosen_vc_in;
         vc_credit_ff     <= vc_credit_in;
         vc_owner_last_ff <= vc_owner_last_in;
      end
   end

   // payload: no reset, owner entries are qualified by owner_valid_ff
   always_ff @(posedge clock) begin
      vc_owner_ff <= vc_owner_in;
      if (req_valid && req_ready) begin
         s1_func_ff <= req_func;
         s1_occ_ff  <= req_occupied_mask;
         s1_tail_ff <= req_front_tail_mask;
         s1_cvc_ff  <= req_credit_vc;
      end
      if (s1_fire) begin
         rsp_sent_ff        <= rsp_sent_in;
         rsp_sent_vc_ff     <= rsp_sent_vc_in;
         rsp_sent_source_ff <= rsp_sent_source_in;
         rsp_sent_tail_ff   <= rsp_sent_tail_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sent        = rsp_sent_ff;
   assign rsp_sent_vc     = rsp_sent_vc_ff;
   assign rsp_sent_source = rsp_sent_source_ff;
   assign rsp_sent_tail   = rsp_sent_tail_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   `COPA_ASSERT_NEXT(a_req_enters_stage, clock, reset, req_valid && req_ready, s1_valid_ff, "accepted word did not reach the input stage")
   `COPA_ASSERT_NOW(a_send_has_credit, clock, reset, s1_fire && is_tick && send, vc_credit_ff[sel_vc] != '0, "flit sent on a channel without credit")
   `COPA_ASSERT_NOW(a_send_from_owner, clock, reset, s1_fire && is_tick && send, own1[sel_vc], "flit sent on a channel with no owner")
   `COPA_ASSERT_NOW(a_idle_result_zero, clock, reset, rsp_valid_ff && !rsp_sent_ff, (rsp_sent_vc_ff == '0) && (rsp_sent_source_ff == '0) && !rsp_sent_tail_ff, "empty result carries nonzero fields")

endmodule
